[src/aarm_pkg.sv]
// Package for the axis-angle rotation matrix block: widths, constants, stage types
// and the elaboration-time tables (CORDIC angles, CORDIC gain, degree-to-radian fractions).
// No dependencies.
package aarm_pkg;

   localparam int ZW         = 58;
   localparam int XW         = 44;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int LEN_W      = 33;

   localparam logic [39:0] PI_Q38   = 40'hC90FDAA221;
   localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C234;
   localparam logic [16:0] TURN_BIAS = 17'd33120;
   localparam logic [15:0] RECIP_360 = 16'd46604;
   localparam logic [23:0] RECIP_180 = 24'd11930465;
   localparam logic [31:0] ONE_Q30   = 32'h4000_0000;

   typedef logic [39:0] frac_tbl_type [180];

   typedef struct packed {
      logic             zero;
      logic [2:0]       neg;
      logic [2:0][31:0] mag;
      logic [63:0]      rad_v;
      logic [63:0]      root;
      logic [2:0][61:0] rem;
      logic [2:0][30:0] quo;
      logic             flip;
      logic [ZW-1:0]    z;
      logic [XW-1:0]    x;
      logic [XW-1:0]    y;
   } item_type;

   typedef struct packed {
      logic             zero_axis;
      logic [8:0][31:0] m;
   } result_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rest;
      logic [63:0] res;
      logic [63:0] bitv;
      int          k;
      rest = v;
      res  = '0;
      bitv = 64'd1 << 62;
      for (k = 0; k < 32; k++) begin
         if ({1'b0, rest} >= {1'b0, res} + {1'b0, bitv}) begin
            rest = rest - res - bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // quotient in the upper half, remainder in the lower half
   function automatic logic [127:0] udivmod64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rest;
      logic [63:0] quo;
      int          k;
      rest = '0;
      quo  = '0;
      for (k = 63; k >= 0; k--) begin
         rest = {rest[63:0], num[k]};
         if (rest >= {1'b0, den}) begin
            rest   = rest - {1'b0, den};
            quo[k] = 1'b1;
         end
      end
      return {quo, rest[63:0]};
   endfunction

   function automatic logic [63:0] cordic_gain(input int n);
      logic [63:0]  p;
      logic [63:0]  s;
      logic [63:0]  q;
      logic [63:0]  r;
      logic [127:0] qr;
      int           i;
      p = 64'd1 << 62;
      for (i = 0; i < 32; i++) begin
         if (i < n) begin
            p = p + (p >> (2 * i));
         end
      end
      s  = isqrt64(p);
      qr = udivmod64(64'd1 << 63, s);
      q  = qr[127:64];
      r  = qr[63:0];
      qr = udivmod64(r << 8, s);
      return (q << 8) + qr[127:64];
   endfunction

   function automatic logic [63:0] atan_q54(input int i);
      logic [63:0]  v;
      logic [63:0]  term;
      logic [127:0] qr;
      int           k;
      int           e;
      v = '0;
      if (i == 0) begin
         v = PI_Q62 >> 2;
      end else begin
         for (k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e < 63) begin
               qr   = udivmod64((64'd1 << 62) >> e, 64'(2 * k + 1));
               term = qr[127:64];
               if (k[0]) begin
                  v = v - term;
               end else begin
                  v = v + term;
               end
            end
         end
      end
      return (v + 64'd128) >> 8;
   endfunction

   function automatic frac_tbl_type build_frac_tbl();
      frac_tbl_type tbl;
      logic [63:0]  prod;
      logic [127:0] qr;
      int           b;
      for (b = 0; b < 180; b++) begin
         prod   = 64'(b) * {24'd0, PI_Q38};
         qr     = udivmod64(prod, 64'd180);
         tbl[b] = qr[103:64];
      end
      return tbl;
   endfunction

   localparam frac_tbl_type FRAC_TBL = build_frac_tbl();

endpackage

[src/axis_angle_rotation_matrix_top.sv]
// Axis-angle (Rodrigues) rotation matrix, one 3x3 Q2.30 matrix per beat.
// Pipeline: input stages, then a chain of 32 square-root, 31 divide and TRIG_ITERATIONS CORDIC stages
// (at most 32), then output stages and the output register.
// Throughput: one beat per cycle while req_stall is low; a one-beat skid register behind the output register.
// Reset: synchronous, active high; clears all valid flags, payload registers are not reset.
module axis_angle_rotation_matrix_top
   import aarm_pkg::*;
#(
   parameter int TRIG_ITERATIONS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_angle_deg,
   input  logic [31:0] req_axis_x,
   input  logic [31:0] req_axis_y,
   input  logic [31:0] req_axis_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_m_r0c0,
   output logic [31:0] rsp_m_r0c1,
   output logic [31:0] rsp_m_r0c2,
   output logic [31:0] rsp_m_r1c0,
   output logic [31:0] rsp_m_r1c1,
   output logic [31:0] rsp_m_r1c2,
   output logic [31:0] rsp_m_r2c0,
   output logic [31:0] rsp_m_r2c1,
   output logic [31:0] rsp_m_r2c2,
   output logic        rsp_zero_axis
);

   localparam int          CORDIC_STEPS = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
   localparam logic [63:0] GAIN         = cordic_gain(CORDIC_STEPS);

   logic       en;
   item_type   sq_item  [SQRT_STEPS+1];
   logic       sq_vld   [SQRT_STEPS+1];
   item_type   dv_item  [DIV_STEPS+1];
   logic       dv_vld   [DIV_STEPS+1];
   item_type   cr_item  [CORDIC_STEPS+1];
   logic       cr_vld   [CORDIC_STEPS+1];
   item_type   cr_seed;
   logic       back_vld;
   result_type back_res;

   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in, take;
   result_type out_data_ff, out_data_in, skid_data_ff, skid_data_in;

   assign en        = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   aarm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .up_valid  (req_valid),
      .angle_deg (req_angle_deg),
      .axis_x    (req_axis_x),
      .axis_y    (req_axis_y),
      .axis_z    (req_axis_z),
      .dn_valid  (sq_vld[0]),
      .dn_item   (sq_item[0])
   );

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      aarm_sqrt_stage #(.IDX(k)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (sq_vld[k]),
         .up_item  (sq_item[k]),
         .dn_valid (sq_vld[k+1]),
         .dn_item  (sq_item[k+1])
      );
   end

   assign dv_vld[0]  = sq_vld[SQRT_STEPS];
   assign dv_item[0] = sq_item[SQRT_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      aarm_div_stage #(.IDX(k)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (dv_vld[k]),
         .up_item  (dv_item[k]),
         .dn_valid (dv_vld[k+1]),
         .dn_item  (dv_item[k+1])
      );
   end

   assign cr_vld[0] = dv_vld[DIV_STEPS];

   always_comb begin
      cr_seed   = dv_item[DIV_STEPS];
      cr_seed.x = XW'(GAIN);
      cr_seed.y = '0;
   end

   assign cr_item[0] = cr_seed;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      aarm_cordic_stage #(.IDX(k)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (cr_vld[k]),
         .up_item  (cr_item[k]),
         .dn_valid (cr_vld[k+1]),
         .dn_item  (cr_item[k+1])
      );
   end

   aarm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .up_valid  (cr_vld[CORDIC_STEPS]),
      .up_item   (cr_item[CORDIC_STEPS]),
      .dn_valid  (back_vld),
      .dn_result (back_res)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      take          = out_valid_ff & ~rsp_stall;
      if (take) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff) begin
         if (take) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (back_vld) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = back_res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = back_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_zero_axis = out_data_ff.zero_axis;
   assign rsp_m_r0c0    = out_data_ff.m[0];
   assign rsp_m_r0c1    = out_data_ff.m[1];
   assign rsp_m_r0c2    = out_data_ff.m[2];
   assign rsp_m_r1c0    = out_data_ff.m[3];
   assign rsp_m_r1c1    = out_data_ff.m[4];
   assign rsp_m_r1c2    = out_data_ff.m[5];
   assign rsp_m_r2c0    = out_data_ff.m[6];
   assign rsp_m_r2c1    = out_data_ff.m[7];
   assign rsp_m_r2c2    = out_data_ff.m[8];

endmodule

[src/aarm_front.sv]
// Input stages: axis magnitude, normalizing shift and sum of squares; angle reduction,
// folding and conversion to radians. Depends on aarm_pkg.
module aarm_front
   import aarm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        up_valid,
   input  logic [31:0] angle_deg,
   input  logic [31:0] axis_x,
   input  logic [31:0] axis_y,
   input  logic [31:0] axis_z,
   output logic        dn_valid,
   output item_type    dn_item
);

   localparam logic signed [25:0] S_FULL    = 26'sd23592960;
   localparam logic signed [25:0] S_HALF    = 26'sd11796480;
   localparam logic signed [25:0] S_QUARTER = 26'sd5898240;

   typedef struct packed {
      logic             zero;
      logic [2:0]       neg;
      logic [2:0][31:0] mag;
      logic [63:0]      sum;
   } ax_type;

   logic [6:0] vld_ff;

   logic [2:0][31:0] axis_in;
   logic [2:0][31:0] mag1_in, mag1_ff;
   logic [2:0]       neg1_in, neg1_ff;
   logic             zero1_in, zero1_ff;
   logic [4:0]       sh1_in, sh1_ff;
   logic [16:0]      hp1_in, hp1_ff;
   logic [32:0]      hq1_in, hq1_ff;
   logic [15:0]      lo1_ff;
   logic [31:0]      mmax;
   logic [4:0]       msb;

   logic [2:0][31:0] mag2_in, mag2_ff;
   logic [2:0][63:0] sq2_in, sq2_ff;
   logic [2:0]       neg2_ff;
   logic             zero2_ff;
   logic [24:0]      dmod2_in, dmod2_ff;
   logic [8:0]       hq_top;
   logic [8:0]       rem9;

   ax_type           ax3_in, ax3_ff, ax4_ff, ax5_ff, ax6_ff, ax7_ff;
   logic signed [25:0] dw, df;
   logic             flip3_in, flip3_ff, flip4_ff, flip5_ff, flip6_ff, flip7_ff;
   logic [22:0]      dm3_in, dm3_ff, dm4_ff;
   logic             dneg3_ff, dneg4_ff, dneg5_ff, dneg6_ff;

   logic [46:0]      dprod4_in, dprod4_ff;
   logic [15:0]      a5_in, a5_ff;
   logic [7:0]       b5_in, b5_ff;
   logic [35:0]      hi6_in, hi6_ff, lo6_in, lo6_ff;
   logic [39:0]      frac6_ff;
   logic [55:0]      zq;
   logic [ZW-1:0]    z7_in, z7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], up_valid};
      end
   end

   assign axis_in = {axis_z, axis_y, axis_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = axis_in[i][31];
         mag1_in[i] = axis_in[i][31] ? (32'd0 - axis_in[i]) : axis_in[i];
      end
      mmax = mag1_in[0];
      if (mag1_in[1] > mmax) begin
         mmax = mag1_in[1];
      end
      if (mag1_in[2] > mmax) begin
         mmax = mag1_in[2];
      end
      msb = '0;
      for (int b = 0; b < 32; b++) begin
         if (mmax[b]) begin
            msb = 5'(b);
         end
      end
      sh1_in   = (msb >= 5'd30) ? 5'd0 : (5'd30 - msb);
      zero1_in = (mmax == 32'd0);
      hp1_in   = {angle_deg[31], angle_deg[31:16]} + TURN_BIAS;
      hq1_in   = {16'd0, hp1_in} * {17'd0, RECIP_360};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         zero1_ff <= zero1_in;
         sh1_ff   <= sh1_in;
         hp1_ff   <= hp1_in;
         hq1_ff   <= hq1_in;
         lo1_ff   <= angle_deg[15:0];
      end
   end

   always_comb begin
      hq_top   = hq1_ff[32:24];
      rem9     = 9'(hp1_ff - {8'd0, hq_top} * 17'd360);
      dmod2_in = {rem9, lo1_ff};
      for (int i = 0; i < 3; i++) begin
         mag2_in[i] = mag1_ff[i] << sh1_ff;
         sq2_in[i]  = {32'd0, mag2_in[i]} * {32'd0, mag2_in[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag2_ff  <= mag2_in;
         sq2_ff   <= sq2_in;
         neg2_ff  <= neg1_ff;
         zero2_ff <= zero1_ff;
         dmod2_ff <= dmod2_in;
      end
   end

   always_comb begin
      ax3_in.zero = zero2_ff;
      ax3_in.neg  = neg2_ff;
      ax3_in.mag  = mag2_ff;
      ax3_in.sum  = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
      dw = $signed({1'b0, dmod2_ff});
      if (dw > S_HALF) begin
         dw = dw - S_FULL;
      end
      df       = dw;
      flip3_in = 1'b0;
      if (dw > S_QUARTER) begin
         df       = dw - S_HALF;
         flip3_in = 1'b1;
      end else if (dw < -S_QUARTER) begin
         df       = dw + S_HALF;
         flip3_in = 1'b1;
      end
      dm3_in = df[25] ? 23'(-df) : 23'(df);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax3_ff   <= ax3_in;
         flip3_ff <= flip3_in;
         dm3_ff   <= dm3_in;
         dneg3_ff <= df[25];
      end
   end

   assign dprod4_in = {24'd0, dm3_ff} * {23'd0, RECIP_180};

   always_ff @(posedge clock) begin
      if (en) begin
         ax4_ff    <= ax3_ff;
         flip4_ff  <= flip3_ff;
         dm4_ff    <= dm3_ff;
         dneg4_ff  <= dneg3_ff;
         dprod4_ff <= dprod4_in;
      end
   end

   assign a5_in = dprod4_ff[46:31];
   assign b5_in = 8'(dm4_ff - {7'd0, a5_in} * 23'd180);

   always_ff @(posedge clock) begin
      if (en) begin
         ax5_ff   <= ax4_ff;
         flip5_ff <= flip4_ff;
         dneg5_ff <= dneg4_ff;
         a5_ff    <= a5_in;
         b5_ff    <= b5_in;
      end
   end

   assign hi6_in = {20'd0, a5_ff} * {16'd0, PI_Q38[39:20]};
   assign lo6_in = {20'd0, a5_ff} * {16'd0, PI_Q38[19:0]};

   always_ff @(posedge clock) begin
      if (en) begin
         ax6_ff   <= ax5_ff;
         flip6_ff <= flip5_ff;
         dneg6_ff <= dneg5_ff;
         hi6_ff   <= hi6_in;
         lo6_ff   <= lo6_in;
         frac6_ff <= FRAC_TBL[b5_ff];
      end
   end

   assign zq    = {hi6_ff, 20'd0} + {20'd0, lo6_ff} + {16'd0, frac6_ff};
   assign z7_in = dneg6_ff ? (ZW'(0) - ZW'(zq)) : ZW'(zq);

   always_ff @(posedge clock) begin
      if (en) begin
         ax7_ff   <= ax6_ff;
         flip7_ff <= flip6_ff;
         z7_ff    <= z7_in;
      end
   end

   always_comb begin
      dn_item.zero  = ax7_ff.zero;
      dn_item.neg   = ax7_ff.neg;
      dn_item.mag   = ax7_ff.mag;
      dn_item.rad_v = ax7_ff.sum;
      dn_item.root  = '0;
      for (int i = 0; i < 3; i++) begin
         dn_item.rem[i] = {ax7_ff.mag[i], 30'd0};
      end
      dn_item.quo  = '0;
      dn_item.flip = flip7_ff;
      dn_item.z    = z7_ff;
      dn_item.x    = '0;
      dn_item.y    = '0;
   end

   assign dn_valid = vld_ff[6];

endmodule

[src/aarm_sqrt_stage.sv]
// One step of the integer square root of the axis sum of squares.
// Depends on aarm_pkg.
module aarm_sqrt_stage
   import aarm_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     up_valid,
   input  item_type up_item,
   output logic     dn_valid,
   output item_type dn_item
);

   localparam logic [63:0] BITV = 64'd1 << (62 - 2 * IDX);

   logic     vld_ff;
   item_type item_in, item_ff;

   always_comb begin
      item_in = up_item;
      if ({1'b0, up_item.rad_v} >= {1'b0, up_item.root} + {1'b0, BITV}) begin
         item_in.rad_v = up_item.rad_v - up_item.root - BITV;
         item_in.root  = (up_item.root >> 1) + BITV;
      end else begin
         item_in.root = up_item.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_item  = item_ff;

endmodule

[src/aarm_div_stage.sv]
// One quotient bit of the three axis divisions by the axis length.
// Depends on aarm_pkg.
module aarm_div_stage
   import aarm_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     up_valid,
   input  item_type up_item,
   output logic     dn_valid,
   output item_type dn_item
);

   localparam int J = DIV_STEPS - 1 - IDX;

   logic        vld_ff;
   item_type    item_in, item_ff;
   logic [63:0] dsh;

   always_comb begin
      item_in = up_item;
      dsh     = {31'd0, up_item.root[LEN_W-1:0]} << J;
      for (int l = 0; l < 3; l++) begin
         if ({2'b00, up_item.rem[l]} >= dsh) begin
            item_in.rem[l]    = up_item.rem[l] - dsh[61:0];
            item_in.quo[l][J] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_item  = item_ff;

endmodule

[src/aarm_cordic_stage.sv]
// One CORDIC rotation step for cosine and sine of the folded angle.
// Depends on aarm_pkg.
module aarm_cordic_stage
   import aarm_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     up_valid,
   input  item_type up_item,
   output logic     dn_valid,
   output item_type dn_item
);

   localparam logic [ZW-1:0] ATAN = ZW'(atan_q54(IDX));

   logic               vld_ff;
   item_type           item_in, item_ff;
   logic signed [XW-1:0] xs, ys, dx, dy;

   always_comb begin
      item_in = up_item;
      xs      = $signed(up_item.x);
      ys      = $signed(up_item.y);
      dx      = ys >>> IDX;
      dy      = xs >>> IDX;
      if (!up_item.z[ZW-1]) begin
         item_in.x = XW'(xs - dx);
         item_in.y = XW'(ys + dy);
         item_in.z = up_item.z - ATAN;
      end else begin
         item_in.x = XW'(xs + dx);
         item_in.y = XW'(ys - dy);
         item_in.z = up_item.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_item  = item_ff;

endmodule

[src/aarm_back.sv]
// Output stages: round cosine and sine, form the unit axis and assemble the nine
// matrix elements with rounding and saturation. Depends on aarm_pkg.
module aarm_back
   import aarm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       up_valid,
   input  item_type   up_item,
   output logic       dn_valid,
   output result_type dn_result
);

   localparam logic signed [XW-1:0] S_ONE  = XW'(ONE_Q30);
   localparam logic signed [63:0]   HALF_LSB = 64'sd536870912;

   logic [3:0] vld_ff;

   logic signed [XW-1:0] xr, yr, cw, sw;
   logic signed [31:0]   c1_in, s1_in, c1_ff, s1_ff;
   logic signed [31:0]   u1_in [3];
   logic signed [31:0]   u1_ff [3];
   logic                 zero1_ff;

   logic signed [32:0]   t2_ff;
   logic signed [31:0]   c2_ff, s2_ff;
   logic signed [63:0]   uu2_ff [3][3];
   logic signed [32:0]   k2_in [3][3];
   logic signed [32:0]   k2_ff [3][3];
   logic                 zero2_ff;

   logic signed [63:0]   ar [3][3];
   logic signed [31:0]   a3 [3][3];
   logic signed [63:0]   pt3_ff [3][3];
   logic signed [63:0]   ps3_ff [3][3];
   logic signed [31:0]   c3_ff;
   logic                 zero3_ff;

   logic signed [63:0]   acc [3][3];
   logic signed [63:0]   ev [3][3];
   result_type           res_in, res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], up_valid};
      end
   end

   always_comb begin
      xr = $signed(up_item.x) + XW'(512);
      yr = $signed(up_item.y) + XW'(512);
      cw = xr >>> 10;
      sw = yr >>> 10;
      if (cw > S_ONE) begin
         cw = S_ONE;
      end else if (cw < -S_ONE) begin
         cw = -S_ONE;
      end
      if (sw > S_ONE) begin
         sw = S_ONE;
      end else if (sw < -S_ONE) begin
         sw = -S_ONE;
      end
      c1_in = up_item.flip ? -32'(cw) : 32'(cw);
      s1_in = up_item.flip ? -32'(sw) : 32'(sw);
      for (int i = 0; i < 3; i++) begin
         u1_in[i] = up_item.neg[i] ? -$signed({1'b0, up_item.quo[i]})
                                   : $signed({1'b0, up_item.quo[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff    <= c1_in;
         s1_ff    <= s1_in;
         u1_ff    <= u1_in;
         zero1_ff <= up_item.zero;
      end
   end

   always_comb begin
      k2_in[0][0] = '0;
      k2_in[0][1] = -33'(u1_ff[2]);
      k2_in[0][2] = 33'(u1_ff[1]);
      k2_in[1][0] = 33'(u1_ff[2]);
      k2_in[1][1] = '0;
      k2_in[1][2] = -33'(u1_ff[0]);
      k2_in[2][0] = -33'(u1_ff[1]);
      k2_in[2][1] = 33'(u1_ff[0]);
      k2_in[2][2] = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_ff    <= $signed({1'b0, ONE_Q30}) - 33'(c1_ff);
         c2_ff    <= c1_ff;
         s2_ff    <= s1_ff;
         k2_ff    <= k2_in;
         zero2_ff <= zero1_ff;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               uu2_ff[r][c] <= 64'(u1_ff[r]) * 64'(u1_ff[c]);
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            ar[r][c] = (uu2_ff[r][c] + HALF_LSB) >>> 30;
            a3[r][c] = 32'(ar[r][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff    <= c2_ff;
         zero3_ff <= zero2_ff;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               pt3_ff[r][c] <= 64'(t2_ff) * 64'(a3[r][c]);
               ps3_ff[r][c] <= 64'(s2_ff) * 64'(k2_ff[r][c]);
            end
         end
      end
   end

   always_comb begin
      res_in.zero_axis = zero3_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            acc[r][c] = pt3_ff[r][c] + ps3_ff[r][c] + HALF_LSB;
            if (r == c) begin
               acc[r][c] = acc[r][c] + (64'(c3_ff) <<< 30);
            end
            ev[r][c] = acc[r][c] >>> 30;
            if (ev[r][c] > 64'sd2147483647) begin
               res_in.m[r * 3 + c] = 32'h7FFF_FFFF;
            end else if (ev[r][c] < -64'sd2147483648) begin
               res_in.m[r * 3 + c] = 32'h8000_0000;
            end else begin
               res_in.m[r * 3 + c] = ev[r][c][31:0];
            end
            if (zero3_ff) begin
               res_in.m[r * 3 + c] = (r == c) ? ONE_Q30 : 32'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign dn_valid  = vld_ff[3];
   assign dn_result = res_ff;

endmodule

[test/tb.sv]
// Testbench for axis_angle_rotation_matrix_top: drives angle/axis beats, predicts each
// Rodrigues matrix in fixed point and checks every response beat in order.
// Depends on src/aarm_pkg.sv and src/axis_angle_rotation_matrix_top.sv.
module tb;
   import aarm_pkg::*;

   localparam int          CORDIC_STEPS = 24;
   localparam int          N_RANDOM     = 1130;
   localparam int          CYCLE_LIMIT  = 600000;
   localparam longint      DEG_360      = 64'sd23592960;
   localparam longint      DEG_180      = 64'sd11796480;
   localparam longint      DEG_90       = 64'sd5898240;
   localparam longint      UNIT_Q30     = 64'sd1073741824;
   localparam longint unsigned PI_Q38_TB = 64'hC90FDAA221;

   typedef struct {
      logic [31:0] m [9];
      logic        zero_axis;
   } rot_type;

   typedef struct packed {
      logic [31:0] angle;
      logic [31:0] ax;
      logic [31:0] ay;
      logic [31:0] az;
      logic        ident;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_angle_deg;
   logic [31:0] req_axis_x;
   logic [31:0] req_axis_y;
   logic [31:0] req_axis_z;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_m [9];
   logic        rsp_zero_axis;

   rot_type matrix_q[$];
   longint  atan_tbl [32];
   longint  cordic_k;
   int      n_fail;
   int      cycles;
   bit      burst;
   int      stall_left;

   axis_angle_rotation_matrix_top #(.TRIG_ITERATIONS(CORDIC_STEPS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_angle_deg(req_angle_deg), .req_axis_x(req_axis_x),
      .req_axis_y(req_axis_y), .req_axis_z(req_axis_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_m_r0c0(rsp_m[0]), .rsp_m_r0c1(rsp_m[1]), .rsp_m_r0c2(rsp_m[2]),
      .rsp_m_r1c0(rsp_m[3]), .rsp_m_r1c1(rsp_m[4]), .rsp_m_r1c2(rsp_m[5]),
      .rsp_m_r2c0(rsp_m[6]), .rsp_m_r2c1(rsp_m[7]), .rsp_m_r2c2(rsp_m[8]),
      .rsp_zero_axis(rsp_zero_axis)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, probe;
      int k;
      root  = 0;
      probe = 64'd1 << 62;
      for (k = 0; k < 32; k++) begin
         if ({1'b0, v} >= {1'b0, root} + {1'b0, probe}) begin
            v    = v - root - probe;
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic void build_cordic_tables();
      longint unsigned p, s, q, r, v, term;
      int i, k;
      p = 64'd1 << 62;
      for (i = 0; i < CORDIC_STEPS; i++) p = p + (p >> (2 * i));
      s = int_sqrt(p);
      q = (64'd1 << 63) / s;
      r = (64'd1 << 63) % s;
      cordic_k = longint'((q << 8) + ((r << 8) / s));
      for (i = 0; i < 32; i++) begin
         if (i == 0) begin
            v = 64'hC90FDAA22168C234 >> 2;
         end else begin
            v = 0;
            for (k = 0; i * (2 * k + 1) < 63; k++) begin
               term = ((64'd1 << 62) >> (i * (2 * k + 1))) / longint'(2 * k + 1);
               if (k % 2) v = v - term;
               else v = v + term;
            end
         end
         atan_tbl[i] = longint'((v + 128) >> 8);
      end
   endfunction

   function automatic longint unit_clamp(longint v);
      if (v > UNIT_Q30) return UNIT_Q30;
      if (v < -UNIT_Q30) return -UNIT_Q30;
      return v;
   endfunction

   function automatic rot_type rodrigues(logic [31:0] ang, logic [31:0] ax, logic [31:0] ay,
                                         logic [31:0] az);
      rot_type         r;
      longint          a [3];
      longint          u [3];
      longint          kx [9];
      longint unsigned mg [3];
      longint unsigned mx, sum, len, dm;
      longint          d, z, c, s, t, x, y, dx, dy, aa, acc, e;
      bit              flip;
      int              i, j, sh;
      a[0] = longint'($signed(ax));
      a[1] = longint'($signed(ay));
      a[2] = longint'($signed(az));
      for (i = 0; i < 3; i++) mg[i] = (a[i] < 0) ? -a[i] : a[i];
      mx = mg[0];
      if (mg[1] > mx) mx = mg[1];
      if (mg[2] > mx) mx = mg[2];
      if (mx == 0) begin
         for (i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? 32'h4000_0000 : 32'd0;
         r.zero_axis = 1'b1;
         return r;
      end
      sh = 0;
      while (mx < (64'd1 << 30)) begin
         mx = mx << 1;
         sh++;
      end
      sum = 0;
      for (i = 0; i < 3; i++) begin
         mg[i] = mg[i] << sh;
         sum   = sum + mg[i] * mg[i];
      end
      len = int_sqrt(sum);
      for (i = 0; i < 3; i++) begin
         u[i] = longint'((mg[i] << 30) / len);
         if (a[i] < 0) u[i] = -u[i];
      end
      d = longint'($signed(ang)) % DEG_360;
      if (d < 0) d += DEG_360;
      if (d > DEG_180) d -= DEG_360;
      flip = 0;
      if (d > DEG_90) begin
         d -= DEG_180;
         flip = 1;
      end else if (d < -DEG_90) begin
         d += DEG_180;
         flip = 1;
      end
      dm = (d < 0) ? -d : d;
      z  = longint'((dm * PI_Q38_TB) / 180);
      if (d < 0) z = -z;
      x = cordic_k;
      y = 0;
      for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= atan_tbl[i];
         end else begin
            x += dx;
            y -= dy;
            z += atan_tbl[i];
         end
      end
      c = unit_clamp((x + 512) >>> 10);
      s = unit_clamp((y + 512) >>> 10);
      if (flip) begin
         c = -c;
         s = -s;
      end
      t = UNIT_Q30 - c;
      kx = '{0, -u[2], u[1], u[2], 0, -u[0], -u[1], u[0], 0};
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            aa  = (u[i] * u[j] + (64'sd1 << 29)) >>> 30;
            acc = t * aa + s * kx[i * 3 + j];
            if (i == j) acc += c * UNIT_Q30;
            e = (acc + (64'sd1 << 29)) >>> 30;
            if (e > 64'sd2147483647) e = 64'sd2147483647;
            if (e < -64'sd2147483648) e = -64'sd2147483648;
            r.m[i * 3 + j] = e[31:0];
         end
      end
      r.zero_axis = 1'b0;
      return r;
   endfunction

   function automatic logic [31:0] rand_component();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom_range(0, 255) - 128;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4, 5: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_angle();
      case ($urandom_range(0, 7))
         0: return 32'((longint'($urandom_range(0, 16)) - 8) * DEG_90);
         1: return 32'((longint'($urandom_range(0, 8)) - 4) * DEG_90
                       + longint'($urandom_range(0, 4)) - 2);
         2, 3: return 32'(longint'($urandom_range(0, 32'(2 * DEG_360))) - DEG_360);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_matrix_req(logic [31:0] ang, logic [31:0] ax, logic [31:0] ay,
                                  logic [31:0] az, bit ident);
      rot_type exp_m;
      int      gap;
      int      i;
      gap = 0;
      if (!burst) begin
         case ($urandom_range(0, 19))
            0: gap = $urandom_range(10, 60);
            1, 2, 3, 4: gap = $urandom_range(1, 3);
            default: gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_angle_deg <= ang;
      req_axis_x    <= ax;
      req_axis_y    <= ay;
      req_axis_z    <= az;
      do @(posedge clock); while (req_stall);
      if (ident) begin
         for (i = 0; i < 9; i++) exp_m.m[i] = (i % 4 == 0) ? ONE_Q30 : 32'd0;
         exp_m.zero_axis = 1'b1;
      end else begin
         exp_m = rodrigues(ang, ax, ay, az);
      end
      matrix_q.push_back(exp_m);
   endtask

   stim_row_type directed [] = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
      '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0},
      '{32'h005A_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b0},
      '{32'hFFA6_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0},
      '{32'h00B4_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0},
      '{32'hFF4C_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0},
      '{32'h0168_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b0},
      '{32'h005A_0001, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0},
      '{32'h00B3_FFFF, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000, 1'b0},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0},
      '{32'h002D_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0},
      '{32'h001E_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b0},
      '{32'hFFE2_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b0},
      '{32'h0087_8000, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0},
      '{32'h0000_0001, 32'h1234_5678, 32'hEDCB_A988, 32'h0BAD_F00D, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0},
      '{32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0}
   };

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rot_type exp_m;
      int      i;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (matrix_q.size() == 0) begin
               $error("response beat with no matrix pending");
               n_fail++;
            end else begin
               exp_m = matrix_q.pop_front();
               for (i = 0; i < 9; i++) begin
                  if (rsp_m[i] !== exp_m.m[i]) begin
                     $error("m_r%0dc%0d: expected %h, got %h", i / 3, i % 3, exp_m.m[i],
                            rsp_m[i]);
                     n_fail++;
                  end
               end
               if (rsp_zero_axis !== exp_m.zero_axis) begin
                  $error("zero_axis: expected %b, got %b", exp_m.zero_axis, rsp_zero_axis);
                  n_fail++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (burst) begin
            rsp_stall <= 1'b0;
         end else begin
            case ($urandom_range(0, 19))
               0: begin
                  rsp_stall  <= 1'b1;
                  stall_left <= $urandom_range(10, 50);
               end
               1, 2, 3, 4: begin
                  rsp_stall  <= 1'b1;
                  stall_left <= $urandom_range(0, 2);
               end
               default: rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   initial begin
      int n;
      n_fail        = 0;
      cycles        = 0;
      burst         = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_angle_deg = '0;
      req_axis_x    = '0;
      req_axis_y    = '0;
      req_axis_z    = '0;
      rsp_stall     = 1'b0;
      stall_left    = 0;
      build_cordic_tables();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[n])
         send_matrix_req(directed[n].angle, directed[n].ax, directed[n].ay, directed[n].az,
                         directed[n].ident);
      for (n = 0; n < N_RANDOM; n++) begin
         burst = (n >= 400 && n < 520);
         if ($urandom_range(0, 29) == 0)
            send_matrix_req(rand_angle(), 32'd0, 32'd0, 32'd0, 1'b0);
         else
            send_matrix_req(rand_angle(), rand_component(), rand_component(),
                            rand_component(), 1'b0);
      end
      burst = 0;
      req_valid <= 1'b0;
      while (matrix_q.size() > 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (n_fail == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
